@@ rtl/mqsb_pkg.sv @@
package mqsb_pkg;

  // pool and queue sizes
  localparam int CELLS  = 1024;
  localparam int QUEUES = 16;

  // field widths
  localparam int DATA_W = 32;
  localparam int QID_W  = 4;
  localparam int ST_W   = 2;

  // a pointer holds a cell number or the null code, which is CELLS
  localparam int PTR_W  = $clog2(CELLS + 1);
  localparam int ADDR_W = $clog2(CELLS);

  localparam logic [PTR_W-1:0] NIL = PTR_W'(CELLS);

  // opcodes
  localparam logic OP_ENQ = 1'b0;
  localparam logic OP_DEQ = 1'b1;

  // result status codes
  localparam logic [ST_W-1:0] ST_DONE  = 2'd0;
  localparam logic [ST_W-1:0] ST_FULL  = 2'd1;
  localparam logic [ST_W-1:0] ST_EMPTY = 2'd2;

  typedef logic [PTR_W-1:0] ptr_t;

endpackage

@@ rtl/mqsb_ram.sv @@
module mqsb_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    // read data holds while no read is issued
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

@@ rtl/multi_queue_shared_buffer_unit.sv @@
// channel | direction | handshake            | payload
// --------+-----------+----------------------+-------------------------
// in      | input     | in_valid / in_ready   | opcode, queue_id, value
// out     | output    | out_valid / out_ready | status, data_out
//
// on accept the link and data memories are read; in the execute state a done item
// writes back one link word (or a head pointer), the data word on enqueue, the
// queue and free stack pointers, and the result register is loaded
// reset (rst, synchronous) empties all queues; never-used cells follow a fill count
// a result waiting in the output register does not block the next accept;
// that item then holds in the execute state until the result is taken
module multi_queue_shared_buffer_unit (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic                                opcode,
  input  logic [mqsb_pkg::QID_W-1:0]          queue_id,
  input  logic signed [mqsb_pkg::DATA_W-1:0]  value,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic [mqsb_pkg::ST_W-1:0]           status,
  output logic signed [mqsb_pkg::DATA_W-1:0]  data_out
);
  import mqsb_pkg::*;

  localparam logic S_IDLE = 1'b0;
  localparam logic S_EXEC = 1'b1;

  logic state;

  // item held for the execute state
  logic              op_r;
  logic [QID_W-1:0]  q_r;
  logic [DATA_W-1:0] val_r;

  // free stack top and count of cells ever taken from the fresh region
  ptr_t free_head, free_head_next;
  ptr_t fill, fill_next;

  // per-queue head and tail pointers
  ptr_t head [QUEUES];
  ptr_t tail [QUEUES];

  logic accept;
  logic go;

  // memory ports
  ptr_t              link_rd;
  logic [DATA_W-1:0] data_rd;
  logic              link_we;
  logic [ADDR_W-1:0] link_wa;
  ptr_t              link_wd;
  logic              data_we;
  ptr_t              rd_ptr;

  // pointer updates for the queue in hand
  logic head_we, tail_we;
  ptr_t head_val, tail_val;
  ptr_t cur_head, cur_tail;

  logic [ST_W-1:0]   st_next;
  logic [DATA_W-1:0] dout_next;

  // next cell of a fresh one is simply the one after it
  logic fresh;
  ptr_t pop_next;

  assign in_ready = (state == S_IDLE);
  assign accept   = in_valid && in_ready;
  // the execute state completes once the result register is free or its result is taken
  assign go       = (state == S_EXEC) && (!out_valid || out_ready);

  assign cur_head = head[q_r];
  assign cur_tail = tail[q_r];

  // dequeue reads the head cell, enqueue reads the free stack top
  assign rd_ptr = (opcode == OP_DEQ) ? head[queue_id] : free_head;

  assign fresh    = (free_head >= fill);
  assign pop_next = fresh ? PTR_W'(free_head + 1'b1) : link_rd;

  mqsb_ram #(
    .WIDTH (PTR_W),
    .DEPTH (CELLS)
  ) u_link_ram (
    .clk     (clk),
    .wr_en   (link_we),
    .wr_addr (link_wa),
    .wr_data (link_wd),
    .rd_en   (accept),
    .rd_addr (rd_ptr[ADDR_W-1:0]),
    .rd_data (link_rd)
  );

  mqsb_ram #(
    .WIDTH (DATA_W),
    .DEPTH (CELLS)
  ) u_data_ram (
    .clk     (clk),
    .wr_en   (data_we),
    .wr_addr (free_head[ADDR_W-1:0]),
    .wr_data (val_r),
    .rd_en   (accept),
    .rd_addr (head[queue_id][ADDR_W-1:0]),
    .rd_data (data_rd)
  );

  // read-modify-write of the linked structure
  always_comb begin
    link_we        = 1'b0;
    link_wa        = cur_tail[ADDR_W-1:0];
    link_wd        = free_head;
    data_we        = 1'b0;
    head_we        = 1'b0;
    tail_we        = 1'b0;
    head_val       = NIL;
    tail_val       = NIL;
    free_head_next = free_head;
    fill_next      = fill;
    st_next        = ST_DONE;
    dout_next      = '0;
    if (op_r == OP_ENQ) begin
      if (free_head >= NIL) begin
        st_next = ST_FULL;
      end else begin
        // pop the free top, store the value, append behind the tail
        st_next        = ST_DONE;
        data_we        = go;
        free_head_next = pop_next;
        if (fresh) begin
          fill_next = PTR_W'(fill + 1'b1);
        end
        if (cur_head >= NIL || cur_tail >= NIL) begin
          head_we  = go;
          head_val = free_head;
        end else begin
          link_we = go;
          link_wa = cur_tail[ADDR_W-1:0];
          link_wd = free_head;
        end
        tail_we  = go;
        tail_val = free_head;
      end
    end else begin
      if (cur_head >= NIL) begin
        st_next = ST_EMPTY;
      end else begin
        // unlink the head cell and push it on the free stack
        st_next   = ST_DONE;
        dout_next = data_rd;
        head_we   = go;
        if (cur_head == cur_tail) begin
          // last cell of the queue
          head_val = NIL;
          tail_we  = go;
          tail_val = NIL;
        end else begin
          head_val = link_rd;
        end
        link_we        = go;
        link_wa        = cur_head[ADDR_W-1:0];
        link_wd        = free_head;
        free_head_next = cur_head;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
      free_head <= '0;
      fill      <= '0;
      for (int i = 0; i < QUEUES; i++) begin
        head[i] <= NIL;
        tail[i] <= NIL;
      end
    end else begin
      unique case (state)
        S_IDLE: begin
          if (accept) begin
            state <= S_EXEC;
          end
        end
        S_EXEC: begin
          if (go) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase

      if (go) begin
        out_valid <= 1'b1;
        free_head <= free_head_next;
        fill      <= fill_next;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end

      if (head_we) begin
        head[q_r] <= head_val;
      end
      if (tail_we) begin
        tail[q_r] <= tail_val;
      end
    end
  end

  // item capture and result register
  always_ff @(posedge clk) begin
    if (accept) begin
      op_r  <= opcode;
      q_r   <= queue_id;
      val_r <= value;
    end
    if (go) begin
      status   <= st_next;
      data_out <= dout_next;
    end
  end

  // free stack can only run dry once every fresh cell is handed out
  assert property (@(posedge clk) disable iff (rst)
    (free_head == NIL) |-> (fill == PTR_W'(CELLS)))
    else $error("free stack empty before fresh cells are used up");

  // a valid free top is either a reused cell or the next fresh one
  assert property (@(posedge clk) disable iff (rst)
    (free_head < NIL) |-> (free_head <= fill))
    else $error("free stack top beyond fill count");

  // head and tail of the queue in hand agree on emptiness
  assert property (@(posedge clk) disable iff (rst)
    (state == S_EXEC) |-> ((cur_head < NIL) == (cur_tail < NIL)))
    else $error("queue head and tail disagree");

  // a new result appears only when an item completes in the execute state
  assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> ($past(state) == S_EXEC))
    else $error("result without a finished item");

endmodule
